### sv/lah_pkg.sv
package lah_pkg;

  // modulus of the id arithmetic: 2^32 - 5
  localparam logic [31:0] PRIME_MOD = 32'hFFFF_FFFB;

  localparam int unsigned COEF_W   = 31;
  localparam int unsigned HASH_W   = 32;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned STEP_W   = 5;

  // reset value of the table size register
  localparam logic [31:0] TABLE_SIZE_RESET = 32'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_NEG,
    ST_ACC,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

### sv/lah_if.sv
interface lah_term_if;
  import lah_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [COEF_W-1:0]        coefficient;
  logic signed [HASH_W-1:0] sub_hash;
  logic                     last_term;

  modport source (output valid, output coefficient, output sub_hash, output last_term,
                  input ready);
  modport sink   (input valid, input coefficient, input sub_hash, input last_term,
                  output ready);
endinterface

interface lah_result_if;
  import lah_pkg::*;

  logic            valid;
  logic            ready;
  logic [ID_W-1:0] point_id;
  logic [ID_W-1:0] bucket_index;

  modport source (output valid, output point_id, output bucket_index, input ready);
  modport sink   (input valid, input point_id, input bucket_index, output ready);
endinterface

interface lah_cfg_if;
  import lah_pkg::*;

  logic            valid;
  logic            ready;
  logic [ID_W-1:0] table_size;

  modport source (output valid, output table_size, input ready);
  modport sink   (input valid, input table_size, output ready);
endinterface

### sv/lsh_amplified_bucket_hash.sv
// amplified lsh hash g: folds the k sub-hashes of one point into an id and a bucket
//
// terms  (sink)  : one beat per sub-hash, carrying coefficient, signed sub_hash and
//                  last_term; a beat is taken at a clock edge with valid and ready high
// result (source): one beat per point, on the term marked last: point_id is the sum
//                  of coefficient * sub_hash modulo 2^32-5, bucket_index is point_id
//                  modulo table_size (point_id itself when table_size is zero)
// cfg    (sink)  : writes table_size; always ready, write only while the block is idle
//
// timing: the modular product is built one bit of |sub_hash| per cycle, so a term
// goes through accept, 32 multiply steps, a sign fix and an accumulate before the
// next ready. the bucket comes from a restoring divider, one quotient bit per cycle,
// in 32 steps after the accumulate of a last term; the done state then loads its
// result into the output register
//
// reset (synchronous rst) clears the running total, sets table_size to 1 and drops
// any pending result. the result sits in an output register; the next term is taken
// while it waits, and a later result stalls in its last cycle until that one is taken
module lsh_amplified_bucket_hash (
  input  logic        clk,
  input  logic        rst,
  lah_term_if.sink    terms,
  lah_result_if.source result,
  lah_cfg_if.sink     cfg
);
  import lah_pkg::*;

  // 34-bit forms of p and 2p for the doubling step
  localparam logic [33:0] P_1X = {2'b00, PRIME_MOD};
  localparam logic [33:0] P_2X = {1'b0, PRIME_MOD, 1'b0};

  state_t state, state_next;

  logic [ID_W-1:0]   table_size;
  logic [ID_W-1:0]   total;       // running sum modulo p, always below p
  logic [COEF_W-1:0] coef;
  logic [HASH_W-1:0] mag;         // |sub_hash|, shifted out msb first
  logic              neg;
  logic              last;
  logic [ID_W-1:0]   acc;         // partial product modulo p
  logic [STEP_W-1:0] step;
  logic [ID_W-1:0]   id;
  logic [ID_W-1:0]   dvd;         // id bits fed to the divider, msb first
  logic [ID_W-1:0]   rem;
  logic [ID_W-1:0]   out_id;
  logic [ID_W-1:0]   out_bucket;
  logic              out_valid;

  // control decoded from the state
  logic take_term;
  logic step_last;
  logic load_out;

  // datapath nets
  logic [HASH_W-1:0] sh_bits;
  logic [HASH_W-1:0] mag_in;
  logic [33:0]       dbl;
  logic [33:0]       dbl_m1;
  logic [33:0]       dbl_m2;
  logic [ID_W-1:0]   mul_next;
  logic [ID_W:0]     sum;
  logic [ID_W:0]     sum_red;
  logic [ID_W-1:0]   acc_next;
  logic [ID_W:0]     rem_sh;
  logic [ID_W:0]     rem_sub;
  logic [ID_W-1:0]   rem_next;

  assign sh_bits = terms.sub_hash;
  // two's complement magnitude; -2^31 maps to 2^31, which fits unsigned
  assign mag_in  = sh_bits[HASH_W-1] ? (~sh_bits + 32'd1) : sh_bits;

  // horner step: acc = (2*acc + bit*coef) mod p, the sum stays below 3p
  assign dbl      = {1'b0, acc, 1'b0} + (mag[HASH_W-1] ? {3'b000, coef} : 34'd0);
  assign dbl_m1   = dbl - P_1X;
  assign dbl_m2   = dbl - P_2X;
  assign mul_next = (dbl >= P_2X) ? dbl_m2[ID_W-1:0] :
                    (dbl >= P_1X) ? dbl_m1[ID_W-1:0] : dbl[ID_W-1:0];

  // add the product residue into the total, one conditional subtract of p
  assign sum      = {1'b0, total} + {1'b0, acc};
  assign sum_red  = sum - {1'b0, PRIME_MOD};
  assign acc_next = (sum >= {1'b0, PRIME_MOD}) ? sum_red[ID_W-1:0] : sum[ID_W-1:0];

  // restoring divide step; with a zero table size the remainder just collects id
  assign rem_sh   = {rem, dvd[ID_W-1]};
  assign rem_sub  = rem_sh - {1'b0, table_size};
  assign rem_next = (rem_sh >= {1'b0, table_size}) ? rem_sub[ID_W-1:0] : rem_sh[ID_W-1:0];

  assign step_last = (step == {STEP_W{1'b1}});

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (terms.valid) state_next = ST_MUL;
      ST_MUL:  if (step_last) state_next = ST_NEG;
      ST_NEG:  state_next = ST_ACC;
      ST_ACC:  state_next = last ? ST_DIV : ST_IDLE;
      ST_DIV:  if (step_last) state_next = ST_DONE;
      ST_DONE: if (!out_valid || result.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    take_term = 1'b0;
    load_out  = 1'b0;
    case (state)
      ST_IDLE: take_term = terms.valid;
      ST_DONE: load_out  = !out_valid || result.ready;
      default: begin
        take_term = 1'b0;
        load_out  = 1'b0;
      end
    endcase
  end

  assign terms.ready = (state == ST_IDLE);
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      total      <= '0;
      table_size <= TABLE_SIZE_RESET;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) table_size <= cfg.table_size;
      if (state == ST_ACC) total <= last ? '0 : acc_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (take_term) begin
          coef <= terms.coefficient;
          mag  <= mag_in;
          neg  <= sh_bits[HASH_W-1];
          last <= terms.last_term;
          acc  <= '0;
          step <= '0;
        end
      end
      ST_MUL: begin
        acc  <= mul_next;
        mag  <= {mag[HASH_W-2:0], 1'b0};
        step <= step + 5'd1;
      end
      ST_NEG: begin
        // lift a negative product into 0 .. p-1
        if (neg && (acc != '0)) acc <= PRIME_MOD - acc;
      end
      ST_ACC: begin
        id   <= acc_next;
        dvd  <= acc_next;
        rem  <= '0;
        step <= '0;
      end
      ST_DIV: begin
        rem  <= rem_next;
        dvd  <= {dvd[ID_W-2:0], 1'b0};
        step <= step + 5'd1;
      end
      ST_DONE: begin
        if (load_out) begin
          out_id     <= id;
          out_bucket <= rem;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  assign result.valid        = out_valid;
  assign result.point_id     = out_id;
  assign result.bucket_index = out_bucket;

`ifndef ASSERT_OFF
  // the running total never leaves the residue range
  a_total_range: assert property (@(posedge clk) disable iff (rst)
    total < PRIME_MOD)
    else $error("running total out of residue range");

  // a delivered id is a proper residue
  a_id_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.point_id < PRIME_MOD))
    else $error("point_id out of residue range");

  // the bucket lies inside the table
  a_bucket_range: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (table_size != '0)) |-> (result.bucket_index < table_size))
    else $error("bucket_index not below table_size");

  // a taken term starts the multiply at once
  a_term_starts: assert property (@(posedge clk) disable iff (rst)
    (terms.valid && terms.ready) |=> (state == ST_MUL) && (step == '0))
    else $error("term taken without starting the multiply");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=> $stable(result.point_id) && result.valid)
    else $error("pending result lost or changed");
`endif

endmodule

### sim/tb_lsh_amplified_bucket_hash.sv
`timescale 1ns / 1ps

module tb_lsh_amplified_bucket_hash;
  import lah_pkg::*;

  // generous bound for the hang guard below
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // quiet cycles after the last result before the config port is touched
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned TERMS_PER_PHASE = 250;

  typedef struct {
    logic [COEF_W-1:0] coefficient;
    logic [HASH_W-1:0] sub_hash;
    logic              last_term;
  } term_beat_t;

  typedef struct {
    logic [ID_W-1:0] point_id;
    logic [ID_W-1:0] bucket_index;
  } point_hash_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lah_term_if   terms_if ();
  lah_result_if result_if ();
  lah_cfg_if    cfg_if ();

  lsh_amplified_bucket_hash uut (
    .clk    (clk),
    .rst    (rst),
    .terms  (terms_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  always #5 clk = ~clk;

  // terms waiting to be driven, filled by the sequencer below
  term_beat_t  terms_pending[$];
  // point hashes predicted but not yet seen on the result channel
  point_hash_t hashes_due[$];

  // predictor state: partial id sum and our copy of table_size
  logic [ID_W-1:0] id_sum;
  logic [ID_W-1:0] table_size_model;

  // idle odds in percent, changed only at falling edges
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  int unsigned fail_count;
  int unsigned cycle_count;

  // non-negative residue of coefficient * signed sub_hash modulo 2^32-5
  function automatic logic [ID_W-1:0] product_mod(logic [COEF_W-1:0] coef,
                                                  logic [HASH_W-1:0] sh);
    logic [63:0] magnitude;
    logic [63:0] residue;
    // |sub_hash| fits in 32 bits even for the most negative value
    magnitude = sh[HASH_W-1] ? 64'h1_0000_0000 - 64'(sh) : 64'(sh);
    residue = (64'(coef) * magnitude) % 64'(PRIME_MOD);
    // lift a negative product back into 0 .. 2^32-6
    if (sh[HASH_W-1] && residue != 64'd0)
      residue = 64'(PRIME_MOD) - residue;
    return residue[ID_W-1:0];
  endfunction

  // fold one accepted term into the sum; a last term closes the point
  function automatic void absorb_term(term_beat_t t);
    logic [63:0] sum;
    point_hash_t r;
    sum = (64'(id_sum) + 64'(product_mod(t.coefficient, t.sub_hash))) % 64'(PRIME_MOD);
    id_sum = sum[ID_W-1:0];
    if (t.last_term) begin
      r.point_id = id_sum;
      // table size zero means no reduction at all
      r.bucket_index = (table_size_model != '0) ? id_sum % table_size_model : id_sum;
      hashes_due.insert(hashes_due.size(), r);
      id_sum = '0;
    end
  endfunction

  function automatic void push_term(logic [COEF_W-1:0] coef, logic [HASH_W-1:0] sh,
                                    logic last);
    term_beat_t t;
    t.coefficient = coef;
    t.sub_hash = sh;
    t.last_term = last;
    terms_pending.insert(terms_pending.size(), t);
  endfunction

  // random values leaning toward the edges of each field
  function automatic logic [COEF_W-1:0] pick_coefficient();
    case ($urandom_range(9))
      0: return '1;
      1: return '0;
      2: return COEF_W'($urandom_range(16));
      default: return COEF_W'($urandom());
    endcase
  endfunction

  function automatic logic [HASH_W-1:0] pick_sub_hash();
    case ($urandom_range(11))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'($urandom_range(16));
      4: return -32'($urandom_range(16));
      default: return $urandom();
    endcase
  endfunction

  // mostly whole points of k terms; now and then a run with random last flags
  function automatic void fill_points(int unsigned n);
    int unsigned count;
    int unsigned k;
    count = 0;
    while (count < n) begin
      if ($urandom_range(99) < 85) begin
        k = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        for (int unsigned i = 0; i < k; i++)
          push_term(pick_coefficient(), pick_sub_hash(), i == k - 1);
      end else begin
        k = $urandom_range(1, 6);
        for (int unsigned i = 0; i < k; i++)
          push_term(pick_coefficient(), pick_sub_hash(), 1'($urandom_range(1)));
      end
      count += k;
    end
  endfunction

  // wait until every term is taken and every hash has come back,
  // then give the block time to finish a trailing non-last term
  task automatic settle();
    do @(negedge clk);
    while (terms_pending.size() != 0 || terms_if.valid || hashes_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_table_size(input logic [ID_W-1:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.table_size <= value;
    do @(posedge clk);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    table_size_model = value;
  endtask

  // term driver: predicts each beat as it is taken, then offers the next one
  always @(posedge clk) begin : drive_terms
    term_beat_t taken;
    term_beat_t next_beat;
    if (rst) begin
      terms_if.valid <= 1'b0;
    end else begin
      if (terms_if.valid && terms_if.ready) begin
        taken.coefficient = terms_if.coefficient;
        taken.sub_hash = terms_if.sub_hash;
        taken.last_term = terms_if.last_term;
        absorb_term(taken);
      end
      // the slot is free when nothing is offered or the offer was just taken
      if (!terms_if.valid || terms_if.ready) begin
        if (terms_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_beat = terms_pending.pop_front();
          terms_if.valid <= 1'b1;
          terms_if.coefficient <= next_beat.coefficient;
          terms_if.sub_hash <= next_beat.sub_hash;
          terms_if.last_term <= next_beat.last_term;
        end else begin
          terms_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: each beat against the oldest predicted hash
  always @(posedge clk) begin : check_results
    point_hash_t want;
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (hashes_due.size() == 0) begin
          $display("%0t unexpected result: expected none, actual id %h bucket %h",
                   $time, result_if.point_id, result_if.bucket_index);
          fail_count++;
        end else begin
          want = hashes_due.pop_front();
          if (result_if.point_id !== want.point_id) begin
            $display("%0t point_id mismatch: expected %h actual %h",
                     $time, want.point_id, result_if.point_id);
            fail_count++;
          end
          if (result_if.bucket_index !== want.bucket_index) begin
            $display("%0t bucket_index mismatch: expected %h actual %h",
                     $time, want.bucket_index, result_if.bucket_index);
            fail_count++;
          end
        end
      end
      result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d terms and %0d hashes outstanding",
               $time, terms_pending.size(), hashes_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [ID_W-1:0] phase_table_size;
    // known values on every input before the first edge
    terms_if.valid = 1'b0;
    terms_if.coefficient = '0;
    terms_if.sub_hash = '0;
    terms_if.last_term = 1'b0;
    result_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.table_size = '0;
    id_sum = '0;
    table_size_model = TABLE_SIZE_RESET;
    fail_count = 0;
    cycle_count = 0;
    send_idle_pct = 35;
    recv_idle_pct = 62;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed points under the reset table size
    push_term('0, '0, 1'b1);
    push_term('1, 32'h7fff_ffff, 1'b1);
    // most negative sub-hash with the largest coefficient
    push_term('1, 32'h8000_0000, 1'b1);
    // minus one lands on 2^32-6
    push_term(31'd1, 32'hffff_ffff, 1'b1);
    // negative sub-hash with zero product stays at zero
    push_term('0, 32'h8000_0000, 1'b1);
    push_term(31'd3, -32'd5, 1'b0);
    push_term(31'd7, 32'd2, 1'b1);
    // large terms that wrap the sum several times
    push_term('1, 32'h7fff_ffff, 1'b0);
    push_term('1, 32'h7fff_ffff, 1'b0);
    push_term('1, 32'h7fff_ffff, 1'b0);
    push_term('1, 32'h8000_0000, 1'b1);
    // sum reaching the modulus exactly folds back to zero
    push_term(31'd1, 32'hffff_ffff, 1'b0);
    push_term(31'd1, 32'd1, 1'b1);
    push_term(31'd1, 32'hffff_ffff, 1'b0);
    push_term(31'd1, 32'hffff_ffff, 1'b1);
    // 2^32-2 reduces to 3
    push_term(31'd2, 32'h7fff_ffff, 1'b1);
    push_term(31'd1, 32'h7fff_ffff, 1'b0);
    push_term(31'd1, 32'h7fff_ffff, 1'b0);
    push_term(31'd1, 32'd2, 1'b1);
    settle();

    // random phases, each under its own table size and idle pattern
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: phase_table_size = '0;
        1: phase_table_size = '1;
        2: phase_table_size = PRIME_MOD;
        3: phase_table_size = ID_W'($urandom_range(2, 100));
        4: phase_table_size = $urandom();
        default: phase_table_size = 32'd1;
      endcase
      // receiver slow first, then sender slow, then no idling at all
      if (phase < 2) begin
        send_idle_pct = 35;
        recv_idle_pct = 62;
      end else if (phase < 4) begin
        send_idle_pct = 62;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_table_size(phase_table_size);
      @(negedge clk);
      fill_points(TERMS_PER_PHASE);
      settle();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
